// ===== sv/mcg_pkg.sv =====
// shared types and constants of the midi to cv/gate router
// no dependencies; used by the front stage, the cells, the top level and the testbench
package mcg_pkg;

  localparam int CV_W       = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CV_W-1:0] CV_MAX = 14'h3FFF;

  // output modes, bits 13..11 of a setup register
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_CVGATE = 3'd1;
  localparam logic [2:0] MODE_BEND   = 3'd2;
  localparam logic [2:0] MODE_PRESS  = 3'd3;
  localparam logic [2:0] MODE_CC     = 3'd4;

  // midi message kinds, high nibble of the status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_PRESS    = 4'hD;
  localparam logic [3:0] KIND_BEND     = 4'hE;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  // decoded message as it travels down the chain of cells
  typedef struct packed {
    logic            act;      // kind 0x8..0xE
    logic [3:0]      kind;
    logic [3:0]      chan;
    logic [6:0]      d1;
    logic [6:0]      d2;
    logic [CV_W-1:0] note_cv;  // scaled and clamped note code
  } msg_t;

endpackage

// ===== sv/mcg_msg_if.sv =====
// request channel carrying one three-byte midi message
// no dependencies
interface mcg_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] data_one;
  logic [6:0] data_two;

  modport source (output valid, status_byte, data_one, data_two, input ready);
  modport sink (input valid, status_byte, data_one, data_two, output ready);
endinterface

// ===== sv/mcg_res_if.sv =====
// result channel carrying the four cv codes and the gate, retrigger and update bits
// no dependencies
interface mcg_res_if;
  logic        valid;
  logic        ready;
  logic [13:0] cv_zero;
  logic [13:0] cv_one;
  logic [13:0] cv_two;
  logic [13:0] cv_three;
  logic [3:0]  gate_bits;
  logic [3:0]  retrigger_bits;
  logic [3:0]  updated_bits;

  modport source (output valid, cv_zero, cv_one, cv_two, cv_three, gate_bits,
                  retrigger_bits, updated_bits, input ready);
  modport sink (input valid, cv_zero, cv_one, cv_two, cv_three, gate_bits,
                retrigger_bits, updated_bits, output ready);
endinterface

// ===== sv/mcg_cfg_if.sv =====
// configuration write channel: register index and write data
// no dependencies
interface mcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/midi_to_cv_gate_router.sv =====
// top level of the midi to cv/gate router: front stage followed by a chain of output cells
// depends on mcg_pkg, mcg_msg_if, mcg_res_if, mcg_cfg_if, mcg_prep and mcg_cell
//
// Usage
//   msg_in  : one midi message per request (status byte and two data bytes)
//   res_out : one result per message: cv code of each output, gate bits,
//             retrigger bits and the outputs that matched this message
//   cfg     : register writes, index 0..OUTPUT_COUNT-1 output setups, then
//             note_base and note_gain; always ready, take effect next cycle;
//             write only while no message is in flight
// Pipeline: OUTPUT_COUNT + 1 register stages, one in the front stage (note
//   scaling multiply) and one per output cell.
// Throughput: one message per cycle while results are taken; each cell updates its
//   own output state as the message passes, then hands message and result slots onward.
// Stall: every stage is a register with its own valid; a stalled receiver
//   holds the last stage, and the stages behind it keep filling, so input
//   requests are still taken until every stage is occupied.
// Reset: setups, cv codes, gates and note_base clear, note_gain becomes 1.0
//   (256); the pipeline empties.
// Outputs beyond four are kept internally but not shown on res_out; with
//   fewer than four outputs the missing fields read 0.
module midi_to_cv_gate_router #(
  parameter int OUTPUT_COUNT = 4
) (
  input logic   clk,
  input logic   rst,
  mcg_msg_if.sink   msg_in,
  mcg_res_if.source res_out,
  mcg_cfg_if.sink   cfg
);

  localparam int CVW  = mcg_pkg::CV_W;
  localparam int SHOW = (OUTPUT_COUNT < 4) ? OUTPUT_COUNT : 4;

  logic                       valid [0:OUTPUT_COUNT];
  logic                       ready [0:OUTPUT_COUNT];
  mcg_pkg::msg_t              msg   [0:OUTPUT_COUNT];
  logic [OUTPUT_COUNT*CVW-1:0] cvv   [0:OUTPUT_COUNT];
  logic [OUTPUT_COUNT-1:0]    gates [0:OUTPUT_COUNT];
  logic [OUTPUT_COUNT-1:0]    retr  [0:OUTPUT_COUNT];
  logic [OUTPUT_COUNT-1:0]    upd   [0:OUTPUT_COUNT];
  logic                       cfg_we;
  logic [4*CVW-1:0]           cv_all;
  logic [3:0]                 gate_all;
  logic [3:0]                 retr_all;
  logic [3:0]                 upd_all;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  // front stage
  mcg_prep #(.OUTPUT_COUNT(OUTPUT_COUNT)) u_prep (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg.index),
    .cfg_data    (cfg.data),
    .in_valid    (msg_in.valid),
    .in_ready    (msg_in.ready),
    .status_byte (msg_in.status_byte),
    .data_one    (msg_in.data_one),
    .data_two    (msg_in.data_two),
    .out_valid   (valid[0]),
    .out_ready   (ready[0]),
    .out_msg     (msg[0])
  );

  // result slots start empty
  assign cvv[0]   = '0;
  assign gates[0] = '0;
  assign retr[0]  = '0;
  assign upd[0]   = '0;

  // chain of output cells
  for (genvar i = 0; i < OUTPUT_COUNT; i++) begin : g_cell
    mcg_cell #(.OUTPUT_COUNT(OUTPUT_COUNT), .IDX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg_we     (cfg_we),
      .cfg_idx    (cfg.index),
      .cfg_data   (cfg.data),
      .in_valid   (valid[i]),
      .in_ready   (ready[i]),
      .in_msg     (msg[i]),
      .in_cv      (cvv[i]),
      .in_gates   (gates[i]),
      .in_retrig  (retr[i]),
      .in_upd     (upd[i]),
      .out_valid  (valid[i+1]),
      .out_ready  (ready[i+1]),
      .out_msg    (msg[i+1]),
      .out_cv     (cvv[i+1]),
      .out_gates  (gates[i+1]),
      .out_retrig (retr[i+1]),
      .out_upd    (upd[i+1])
    );
  end

  // map the last stage onto the four result fields
  always_comb begin
    cv_all   = '0;
    gate_all = '0;
    retr_all = '0;
    upd_all  = '0;
    cv_all[SHOW*CVW-1:0] = cvv[OUTPUT_COUNT][SHOW*CVW-1:0];
    gate_all[SHOW-1:0]   = gates[OUTPUT_COUNT][SHOW-1:0];
    retr_all[SHOW-1:0]   = retr[OUTPUT_COUNT][SHOW-1:0];
    upd_all[SHOW-1:0]    = upd[OUTPUT_COUNT][SHOW-1:0];
  end

  assign ready[OUTPUT_COUNT]    = res_out.ready;
  assign res_out.valid          = valid[OUTPUT_COUNT];
  assign res_out.cv_zero        = cv_all[0*CVW +: CVW];
  assign res_out.cv_one         = cv_all[1*CVW +: CVW];
  assign res_out.cv_two         = cv_all[2*CVW +: CVW];
  assign res_out.cv_three       = cv_all[3*CVW +: CVW];
  assign res_out.gate_bits      = gate_all;
  assign res_out.retrigger_bits = retr_all;
  assign res_out.updated_bits   = upd_all;

endmodule

// ===== sv/mcg_prep.sv =====
// front stage: decodes the message and scales the note into a cv code
// depends on mcg_pkg; holds the note_base and note_gain registers
module mcg_prep #(
  parameter int OUTPUT_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mcg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    status_byte,
  input  logic [6:0]                    data_one,
  input  logic [6:0]                    data_two,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mcg_pkg::msg_t                 out_msg
);

  logic [6:0]  note_base;
  logic [15:0] note_gain;
  logic [22:0] prod;
  logic [21:0] scaled;
  logic [mcg_pkg::CV_W-1:0] note_cv;
  mcg_pkg::msg_t msg_next;
  logic take;

  // scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      note_base <= '0;
      note_gain <= 16'd256;
    end else if (cfg_we) begin
      if (cfg_idx == mcg_pkg::CFG_IDX_W'(OUTPUT_COUNT)) begin
        note_base <= cfg_data[6:0];
      end
      if (cfg_idx == mcg_pkg::CFG_IDX_W'(OUTPUT_COUNT + 1)) begin
        note_gain <= cfg_data;
      end
    end
  end

  // (note - base) * 128 * gain >> 8 is (note - base) * gain >> 1
  always_comb begin
    prod   = 23'(data_one - note_base) * 23'(note_gain);
    scaled = prod[22:1];
    if (data_one <= note_base) begin
      note_cv = '0;
    end else if (scaled > 22'(mcg_pkg::CV_MAX)) begin
      note_cv = mcg_pkg::CV_MAX;
    end else begin
      note_cv = scaled[mcg_pkg::CV_W-1:0];
    end
  end

  // message decode
  always_comb begin
    msg_next.kind    = status_byte[7:4];
    msg_next.chan    = status_byte[3:0];
    msg_next.act     = status_byte[7] && (status_byte[7:4] != mcg_pkg::KIND_SYSTEM);
    msg_next.d1      = data_one;
    msg_next.d2      = data_two;
    msg_next.note_cv = note_cv;
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_msg <= msg_next;
    end
  end

endmodule

// ===== sv/mcg_cell.sv =====
// one output cell: holds its setup, cv code and gate, and one stage of the chain
// depends on mcg_pkg; instantiated once per output by the top level
module mcg_cell #(
  parameter int OUTPUT_COUNT = 4,
  parameter int IDX          = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]           cfg_idx,
  input  logic [mcg_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  mcg_pkg::msg_t                           in_msg,
  input  logic [OUTPUT_COUNT*mcg_pkg::CV_W-1:0]   in_cv,
  input  logic [OUTPUT_COUNT-1:0]                 in_gates,
  input  logic [OUTPUT_COUNT-1:0]                 in_retrig,
  input  logic [OUTPUT_COUNT-1:0]                 in_upd,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output mcg_pkg::msg_t                           out_msg,
  output logic [OUTPUT_COUNT*mcg_pkg::CV_W-1:0]   out_cv,
  output logic [OUTPUT_COUNT-1:0]                 out_gates,
  output logic [OUTPUT_COUNT-1:0]                 out_retrig,
  output logic [OUTPUT_COUNT-1:0]                 out_upd
);

  logic [13:0] setup;
  logic [mcg_pkg::CV_W-1:0] cv;
  logic gate;
  logic [mcg_pkg::CV_W-1:0] cv_next;
  logic gate_next;
  logic [2:0] mode;
  logic [3:0] chan;
  logic hit;
  logic note_on;
  logic retrig;
  logic enabled;
  logic take;
  logic cfg_hit;
  logic [OUTPUT_COUNT*mcg_pkg::CV_W-1:0] cv_vec;
  logic [OUTPUT_COUNT-1:0] gate_vec;
  logic [OUTPUT_COUNT-1:0] retrig_vec;
  logic [OUTPUT_COUNT-1:0] upd_vec;

  assign mode    = setup[13:11];
  assign chan    = setup[10:7];
  assign enabled = (mode == mcg_pkg::MODE_CVGATE) || (mode == mcg_pkg::MODE_BEND) ||
                   (mode == mcg_pkg::MODE_PRESS) || (mode == mcg_pkg::MODE_CC);
  assign cfg_hit = cfg_we && (cfg_idx == mcg_pkg::CFG_IDX_W'(IDX));

  // template match on status and first data byte
  always_comb begin
    case (mode)
      mcg_pkg::MODE_CVGATE: hit = (in_msg.kind[3:1] == mcg_pkg::KIND_NOTE_OFF[3:1]) &&
                                  (in_msg.chan == chan);
      mcg_pkg::MODE_BEND:   hit = (in_msg.kind == mcg_pkg::KIND_BEND) && (in_msg.chan == chan);
      mcg_pkg::MODE_PRESS:  hit = (in_msg.kind == mcg_pkg::KIND_PRESS) && (in_msg.chan == chan);
      mcg_pkg::MODE_CC:     hit = (in_msg.kind == mcg_pkg::KIND_CC) && (in_msg.chan == chan) &&
                                  (in_msg.d1 == setup[6:0]);
      default:              hit = 1'b0;
    endcase
    hit = hit && in_msg.act;
  end

  // new cv code and gate of this output
  always_comb begin
    note_on   = (in_msg.kind == mcg_pkg::KIND_NOTE_ON) && (in_msg.d2 != 7'd0);
    cv_next   = cv;
    gate_next = gate;
    retrig    = 1'b0;
    if (hit) begin
      if (note_on) begin
        retrig    = gate;
        cv_next   = in_msg.note_cv;
        gate_next = 1'b1;
      end else if ((in_msg.kind == mcg_pkg::KIND_NOTE_OFF) ||
                   (in_msg.kind == mcg_pkg::KIND_NOTE_ON)) begin
        gate_next = 1'b0;
      end else if (in_msg.kind == mcg_pkg::KIND_BEND) begin
        cv_next = {in_msg.d2, in_msg.d1};
      end else begin
        cv_next = {in_msg.d2, 7'd0};
      end
    end
  end

  // put this output's slot into the vectors handed down the chain
  always_comb begin
    cv_vec     = in_cv;
    gate_vec   = in_gates;
    retrig_vec = in_retrig;
    upd_vec    = in_upd;
    cv_vec[IDX*mcg_pkg::CV_W +: mcg_pkg::CV_W] = enabled ? cv_next : '0;
    gate_vec[IDX]   = gate_next;
    retrig_vec[IDX] = retrig;
    upd_vec[IDX]    = hit;
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // output state, written on a setup write (cv cleared) or when the request passes
  always_ff @(posedge clk) begin
    if (rst) begin
      setup <= '0;
      cv    <= '0;
      gate  <= 1'b0;
    end else if (cfg_hit) begin
      setup <= cfg_data[13:0];
      cv    <= '0;
    end else if (take) begin
      cv   <= cv_next;
      gate <= gate_next;
    end
  end

  // stage register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_msg    <= in_msg;
      out_cv     <= cv_vec;
      out_gates  <= gate_vec;
      out_retrig <= retrig_vec;
      out_upd    <= upd_vec;
    end
  end

endmodule

// ===== tb/midi_to_cv_gate_router_tb.sv =====
// self-checking testbench for the midi to cv/gate router: directed and random midi traffic
// depends on mcg_pkg, mcg_msg_if, mcg_res_if, mcg_cfg_if and midi_to_cv_gate_router
// an in-bench predictor tracks setups, cv codes and gates and checks every result request
module midi_to_cv_gate_router_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUTPUTS         = 4;
  localparam int PIPE_LATENCY    = OUTPUTS + 1;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int HOLD_OFF_CYCLES = 300;

  // register indexes
  localparam logic [3:0] REG_SETUP0    = 4'd0;
  localparam logic [3:0] REG_NOTE_BASE = 4'd4;
  localparam logic [3:0] REG_NOTE_GAIN = 4'd5;

  // status bytes and kinds that no output ever listens to
  localparam logic [7:0] STATUS_ZERO      = 8'h00;
  localparam logic [7:0] STATUS_DATA_TOP  = 8'h7F;
  localparam logic [3:0] KIND_POLY_PRESS  = 4'hA;
  localparam logic [3:0] KIND_PROGRAM     = 4'hC;

  typedef struct packed {
    logic [3:0][mcg_pkg::CV_W-1:0] cv;
    logic [3:0]                    gate;
    logic [3:0]                    retrig;
    logic [3:0]                    updated;
  } cv_result_t;

  logic clk = 1'b0;
  logic rst;

  mcg_msg_if msg_bus();
  mcg_res_if res_bus();
  mcg_cfg_if cfg_bus();

  midi_to_cv_gate_router #(.OUTPUT_COUNT(OUTPUTS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg_in (msg_bus),
    .res_out(res_bus),
    .cfg    (cfg_bus)
  );

  // predictor state
  logic [13:0]              setup_now [OUTPUTS];
  logic [6:0]               base_now;
  logic [15:0]              gain_now;
  logic [mcg_pkg::CV_W-1:0] cv_now [OUTPUTS];
  logic [3:0]               gate_now;

  cv_result_t pending_results [$];

  int fault_count     = 0;
  int results_checked = 0;
  int messages_sent   = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  // receiver stall pattern
  int receiver_hold_off = 0;
  int stall_pct         = 0;
  int stall_left        = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("FAIL midi_to_cv_gate_router");
      $finish;
    end
  end

  // receiver: long hold-off when asked, else a random stall rate that changes now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 50;
        default: stall_pct <= 85;
      endcase
      stall_left <= int'($urandom_range(32, 256));
    end else begin
      stall_left <= stall_left - 1;
    end
    if (receiver_hold_off > 0) begin
      res_bus.ready <= 1'b0;
      receiver_hold_off <= receiver_hold_off - 1;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", results_checked, what, want, got);
    end
  endfunction

  // compare each result request with the oldest prediction
  always @(posedge clk) begin : check_result
    cv_result_t want;
    cv_result_t got;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.cv[0]   = res_bus.cv_zero;
      got.cv[1]   = res_bus.cv_one;
      got.cv[2]   = res_bus.cv_two;
      got.cv[3]   = res_bus.cv_three;
      got.gate    = res_bus.gate_bits;
      got.retrig  = res_bus.retrigger_bits;
      got.updated = res_bus.updated_bits;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("result %0d arrived with nothing pending", results_checked);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < OUTPUTS; i++)
          compare_field($sformatf("cv of output %0d", i), 32'(want.cv[i]), 32'(got.cv[i]));
        compare_field("gate_bits", 32'(want.gate), 32'(got.gate));
        compare_field("retrigger_bits", 32'(want.retrig), 32'(got.retrig));
        compare_field("updated_bits", 32'(want.updated), 32'(got.updated));
      end
      results_checked++;
    end
  end

  function automatic logic [13:0] setup_word(logic [2:0] mode, logic [3:0] chan,
                                             logic [6:0] ccnum);
    return {mode, chan, ccnum};
  endfunction

  // mask and template match of one output against status and first data byte
  function automatic bit output_matches(logic [13:0] s, logic [7:0] st, logic [6:0] d1);
    logic [3:0] chan;
    chan = s[10:7];
    case (s[13:11])
      mcg_pkg::MODE_CVGATE: return (st & 8'hEF) == {mcg_pkg::KIND_NOTE_OFF, chan};
      mcg_pkg::MODE_BEND:   return st == {mcg_pkg::KIND_BEND, chan};
      mcg_pkg::MODE_PRESS:  return st == {mcg_pkg::KIND_PRESS, chan};
      mcg_pkg::MODE_CC:     return st == {mcg_pkg::KIND_CC, chan} && d1 == s[6:0];
      default:              return 1'b0;
    endcase
  endfunction

  // note scaled by gain in q8.8, clamped to the cv range
  function automatic logic [mcg_pkg::CV_W-1:0] note_code(logic [6:0] note);
    int     diff;
    longint scaled;
    diff = int'(note) - int'(base_now);
    if (diff <= 0)
      return '0;
    scaled = (longint'(diff) * 128 * longint'(gain_now)) >>> 8;
    if (scaled > longint'(mcg_pkg::CV_MAX))
      return mcg_pkg::CV_MAX;
    return scaled[mcg_pkg::CV_W-1:0];
  endfunction

  // advance the predicted outputs by one midi message
  function automatic cv_result_t route_message(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    cv_result_t r;
    logic [3:0] kind;
    logic [2:0] mode;
    kind = st[7:4];
    r = '0;
    for (int i = 0; i < OUTPUTS; i++) begin
      if (kind >= mcg_pkg::KIND_NOTE_OFF && kind != mcg_pkg::KIND_SYSTEM &&
          output_matches(setup_now[i], st, d1)) begin
        r.updated[i] = 1'b1;
        if (kind == mcg_pkg::KIND_NOTE_ON && d2 != 7'd0) begin
          r.retrig[i] = gate_now[i];
          cv_now[i] = note_code(d1);
          gate_now[i] = 1'b1;
        end else if (kind == mcg_pkg::KIND_NOTE_OFF || kind == mcg_pkg::KIND_NOTE_ON) begin
          gate_now[i] = 1'b0;
        end else if (kind == mcg_pkg::KIND_BEND) begin
          cv_now[i] = {d2, d1};
        end else begin
          cv_now[i] = {d2, 7'd0};
        end
      end
    end
    for (int i = 0; i < OUTPUTS; i++) begin
      mode = setup_now[i][13:11];
      r.cv[i] = (mode >= mcg_pkg::MODE_CVGATE && mode <= mcg_pkg::MODE_CC) ? cv_now[i] : '0;
    end
    r.gate = gate_now;
    return r;
  endfunction

  // one message request, prediction queued when it is taken
  task automatic send_message(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    @(negedge clk);
    msg_bus.valid       <= 1'b1;
    msg_bus.status_byte <= st;
    msg_bus.data_one    <= d1;
    msg_bus.data_two    <= d2;
    do @(posedge clk); while (!msg_bus.ready);
    pending_results.push_back(route_message(st, d1, d2));
    messages_sent++;
  endtask

  // sender gap, with junk on the payload while no request is offered
  task automatic hold_requests(int cycles);
    @(negedge clk);
    msg_bus.valid       <= 1'b0;
    msg_bus.status_byte <= 8'($urandom_range(0, 255));
    msg_bus.data_one    <= 7'($urandom_range(0, 127));
    msg_bus.data_two    <= 7'($urandom_range(0, 127));
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    hold_requests(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_register(logic [3:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx < OUTPUTS) begin
      setup_now[idx[1:0]] = value[13:0];
      cv_now[idx[1:0]] = '0;
    end else if (idx == REG_NOTE_BASE) begin
      base_now = value[6:0];
    end else if (idx == REG_NOTE_GAIN) begin
      gain_now = value;
    end
    reg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // mostly messages aimed at a configured output, some pure noise
  task automatic pick_message(output logic [7:0] st, output logic [6:0] d1,
                              output logic [6:0] d2);
    logic [13:0] s;
    logic [3:0]  kind;
    logic [3:0]  chan;
    logic [1:0]  o;
    d1 = 7'($urandom_range(0, 127));
    d2 = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 20) begin
      st = 8'($urandom_range(0, 255));
    end else begin
      o = 2'($urandom_range(0, OUTPUTS - 1));
      s = setup_now[o];
      chan = s[10:7];
      if ($urandom_range(0, 9) == 0)
        chan = 4'($urandom_range(0, 15));
      case (s[13:11])
        mcg_pkg::MODE_CVGATE: begin
          kind = ($urandom_range(0, 9) < 6) ? mcg_pkg::KIND_NOTE_ON : mcg_pkg::KIND_NOTE_OFF;
          if ($urandom_range(0, 6) == 0)
            d2 = 7'd0;
          if ($urandom_range(0, 3) == 0)
            d1 = 7'(base_now + $urandom_range(0, 3));
        end
        mcg_pkg::MODE_BEND:  kind = mcg_pkg::KIND_BEND;
        mcg_pkg::MODE_PRESS: kind = mcg_pkg::KIND_PRESS;
        mcg_pkg::MODE_CC: begin
          kind = mcg_pkg::KIND_CC;
          if ($urandom_range(0, 4) != 0)
            d1 = s[6:0];
        end
        default: kind = 4'($urandom_range(mcg_pkg::KIND_NOTE_OFF, mcg_pkg::KIND_BEND));
      endcase
      st = {kind, chan};
    end
  endtask

  // fresh setups per phase, some outputs sharing a channel; scaling extremes first
  task automatic program_random_setup(int phase);
    logic [2:0]  mode;
    logic [3:0]  chan;
    logic [6:0]  ccnum;
    logic [1:0]  spare;
    logic [8:0]  base_pad;
    logic [6:0]  base;
    logic [15:0] gain;
    logic [3:0]  stray_idx;
    logic [15:0] stray_data;
    chan = 4'($urandom_range(0, 15));
    for (int i = 0; i < OUTPUTS; i++) begin
      if ($urandom_range(0, 9) < 8)
        mode = 3'($urandom_range(mcg_pkg::MODE_CVGATE, mcg_pkg::MODE_CC));
      else
        mode = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2) != 0)
        chan = 4'($urandom_range(0, 15));
      ccnum = 7'($urandom_range(0, 127));
      spare = 2'($urandom_range(0, 3));
      write_register(4'(REG_SETUP0 + i), {spare, setup_word(mode, chan, ccnum)});
    end
    case (phase)
      0: begin base = 7'd0;   gain = 16'd256;  end
      1: begin base = 7'd127; gain = 16'hFFFF; end
      2: begin base = 7'd0;   gain = 16'hFFFF; end
      3: begin base = 7'd0;   gain = 16'd0;    end
      default: begin
        base = 7'($urandom_range(0, 127));
        gain = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023))
                                    : 16'($urandom_range(0, 65535));
      end
    endcase
    base_pad = 9'($urandom_range(0, 511));
    write_register(REG_NOTE_BASE, {base_pad, base});
    write_register(REG_NOTE_GAIN, gain);
    // writes past the last register must be ignored
    if ($urandom_range(0, 1) != 0) begin
      stray_idx  = 4'($urandom_range(REG_NOTE_GAIN + 1, 15));
      stray_data = 16'($urandom_range(0, 65535));
      write_register(stray_idx, stray_data);
    end
  endtask

  // everything off after reset: nothing matches, all codes zero
  task automatic test_reset_state();
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd60, 7'd100);
  endtask

  // each mode, retrigger, note-off by both forms, ignored kinds and misses
  task automatic test_mode_routing();
    wait_for_results();
    write_register(REG_SETUP0,          setup_word(mcg_pkg::MODE_CVGATE, 4'd0, 7'd0));
    write_register(4'(REG_SETUP0 + 1), setup_word(mcg_pkg::MODE_BEND, 4'd1, 7'd0));
    write_register(4'(REG_SETUP0 + 2), setup_word(mcg_pkg::MODE_PRESS, 4'd15, 7'd0));
    write_register(4'(REG_SETUP0 + 3), setup_word(mcg_pkg::MODE_CC, 4'd2, 7'd127));
    write_register(REG_NOTE_BASE, 16'd0);
    write_register(REG_NOTE_GAIN, 16'd256);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd127, 7'd127);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd0, 7'd1);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd64, 7'd0);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd64, 7'd64);
    send_message({mcg_pkg::KIND_NOTE_OFF, 4'd0}, 7'd64, 7'd127);
    send_message({mcg_pkg::KIND_BEND, 4'd1}, 7'd127, 7'd127);
    send_message({mcg_pkg::KIND_BEND, 4'd1}, 7'd0, 7'd0);
    send_message({mcg_pkg::KIND_PRESS, 4'd15}, 7'd0, 7'd127);
    send_message({mcg_pkg::KIND_PRESS, 4'd15}, 7'd127, 7'd0);
    send_message({mcg_pkg::KIND_CC, 4'd2}, 7'd127, 7'd127);
    send_message({mcg_pkg::KIND_CC, 4'd2}, 7'd126, 7'd127);
    send_message(STATUS_ZERO, 7'd0, 7'd0);
    send_message(STATUS_DATA_TOP, 7'd127, 7'd127);
    send_message({mcg_pkg::KIND_SYSTEM, 4'd0}, 7'd60, 7'd60);
    send_message({mcg_pkg::KIND_SYSTEM, 4'd15}, 7'd127, 7'd127);
    send_message({KIND_POLY_PRESS, 4'd0}, 7'd60, 7'd60);
    send_message({KIND_PROGRAM, 4'd0}, 7'd1, 7'd1);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd1}, 7'd60, 7'd60);
  endtask

  // note at and below base, clamp at full scale, zero gain
  task automatic test_note_scaling();
    wait_for_results();
    write_register(REG_NOTE_BASE, 16'd127);
    write_register(REG_NOTE_GAIN, 16'hFFFF);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd127, 7'd1);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd0, 7'd1);
    wait_for_results();
    write_register(REG_NOTE_BASE, 16'd0);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd1, 7'd1);
    wait_for_results();
    write_register(REG_NOTE_GAIN, 16'd0);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd127, 7'd127);
  endtask

  // unused modes act as off; an output switched off keeps its open gate
  task automatic test_disabled_outputs();
    wait_for_results();
    write_register(4'(REG_SETUP0 + 1), setup_word(3'd5, 4'd1, 7'd0));
    write_register(4'(REG_SETUP0 + 2), setup_word(3'd6, 4'd15, 7'd0));
    write_register(4'(REG_SETUP0 + 3), setup_word(3'd7, 4'd2, 7'd127));
    write_register(REG_SETUP0, setup_word(mcg_pkg::MODE_OFF, 4'd0, 7'd0));
    send_message({mcg_pkg::KIND_BEND, 4'd1}, 7'd5, 7'd5);
    send_message({mcg_pkg::KIND_NOTE_ON, 4'd0}, 7'd1, 7'd1);
  endtask

  // random traffic in bursts, one configuration per phase
  task automatic test_random_traffic();
    logic [7:0] st;
    logic [6:0] d1;
    logic [6:0] d2;
    int         burst_left;
    burst_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      program_random_setup(phase);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, 48));
          if ($urandom_range(0, 2) != 0)
            hold_requests(int'($urandom_range(1, 10)));
        end
        burst_left--;
        pick_message(st, d1, d2);
        send_message(st, d1, d2);
      end
    end
  endtask

  // long output stall while requests keep coming, then a full drain before more
  task automatic test_output_backpressure();
    logic [7:0] st;
    logic [6:0] d1;
    logic [6:0] d2;
    wait_for_results();
    receiver_hold_off = HOLD_OFF_CYCLES;
    for (int n = 0; n < 40; n++) begin
      pick_message(st, d1, d2);
      send_message(st, d1, d2);
    end
    wait_for_results();
    for (int n = 0; n < 20; n++) begin
      pick_message(st, d1, d2);
      send_message(st, d1, d2);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    msg_bus.valid       = 1'b0;
    msg_bus.status_byte = '0;
    msg_bus.data_one    = '0;
    msg_bus.data_two    = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    res_bus.ready       = 1'b0;
    for (int i = 0; i < OUTPUTS; i++) begin
      setup_now[i] = '0;
      cv_now[i]    = '0;
    end
    gate_now = '0;
    base_now = '0;
    gain_now = 16'd256;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_mode_routing();
    test_note_scaling();
    test_disabled_outputs();
    test_random_traffic();
    test_output_backpressure();

    wait_for_results();
    repeat (4 * PIPE_LATENCY) @(posedge clk);

    $display("%0d midi messages routed, %0d results checked, %0d register writes",
             messages_sent, results_checked, reg_writes);
    $display("covered all modes, scaling extremes, ignored kinds and a %0d-cycle output stall",
             HOLD_OFF_CYCLES);
    if (fault_count == 0)
      $display("PASS midi_to_cv_gate_router");
    else
      $display("FAIL midi_to_cv_gate_router");
    $finish;
  end

endmodule

// ===== midi_to_cv_gate_router.f =====
sv/mcg_pkg.sv
sv/mcg_msg_if.sv
sv/mcg_res_if.sv
sv/mcg_cfg_if.sv
sv/mcg_prep.sv
sv/mcg_cell.sv
sv/midi_to_cv_gate_router.sv
tb/midi_to_cv_gate_router_tb.sv
